[hdl/assert_macros.svh]
// Assertion helpers used by the checker file gesu_chk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with asynchronous active-low reset disable
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, written against the default clk and rst_n names
`define ASSERT_STD(label, prop, msg) \
    `ASSERT_CLK(label, clk, rst_n, prop, msg)

`endif

[hdl/gesu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gesu_pkg
// Types, constants and fixed-point helpers of the linear system solver.
// ----------------------------------------------------------------------------
package gesu_pkg;

    localparam int MAX_SIZE  = 16;
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int STRIDE    = MAX_SIZE + 1;
    localparam int DEPTH     = MAX_SIZE * STRIDE;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int IDX_W     = $clog2(MAX_SIZE);
    localparam int CNT_W     = $clog2(MAX_SIZE + 1);
    localparam int NUM_W     = DATA_W + FRAC_BITS;
    localparam int DCNT_W    = $clog2(NUM_W + 1);
    localparam int SIZE_W    = 5;
    localparam int THR_W     = 16;
    localparam int CFG_IDX_W = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SIZE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_THRESHOLD = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;
    localparam logic [THR_W-1:0]  THR_RESET  = 16'd1;

    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic [3:0]               row;
        logic [4:0]               col;
        logic signed [DATA_W-1:0] value;
        logic                     last_element;
    } item_t;

    typedef struct packed {
        logic [3:0]               index;
        logic signed [DATA_W-1:0] solution;
        logic                     no_solution;
        logic                     last;
    } result_t;

    typedef struct packed {
        logic                     start;
        logic signed [DATA_W-1:0] num;
        logic signed [DATA_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] quot;
    } div_rsp_t;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_PIV_RD,
        ST_PIV_CHK,
        ST_SRCH_RD,
        ST_SRCH_CHK,
        ST_SWP_RD,
        ST_SWP_CAP,
        ST_SWP_WR,
        ST_ROW_RD,
        ST_ROW_DIV,
        ST_ROW_WAIT,
        ST_ELM_RD,
        ST_ELM_MUL,
        ST_ELM_WR,
        ST_FIN_RD,
        ST_FIN_CHK,
        ST_BS_RD,
        ST_BS_X,
        ST_BS_TRD,
        ST_BS_TMUL,
        ST_BS_TSUB,
        ST_BS_DRD,
        ST_BS_DIV,
        ST_BS_WAIT,
        ST_OUT_RD,
        ST_OUT_WR,
        ST_NOSOL
    } state_t;

    // row/column to coefficient address
    function automatic logic [ADDR_W-1:0] cell_addr(logic [CNT_W-1:0] r,
                                                    logic [CNT_W-1:0] c);
        return ADDR_W'(32'(r) * STRIDE + 32'(c));
    endfunction

    // clamp the size register into 1..MAX_SIZE
    function automatic logic [CNT_W-1:0] eff_size(logic [SIZE_W-1:0] ms);
        if (ms == '0)
            return CNT_W'(1);
        else if (32'(ms) > MAX_SIZE)
            return CNT_W'(MAX_SIZE);
        else
            return CNT_W'(ms);
    endfunction

    function automatic logic [DATA_W-1:0] mag(logic signed [DATA_W-1:0] v);
        return v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
    endfunction

    // pivot counts as zero
    function automatic logic below(logic signed [DATA_W-1:0] v, logic [THR_W-1:0] thr);
        logic [THR_W-1:0] t;
        t = (thr == '0) ? THR_W'(1) : thr;
        return mag(v) < DATA_W'(t);
    endfunction

    // usable substitute entry
    function automatic logic usable(logic signed [DATA_W-1:0] v, logic [THR_W-1:0] thr);
        return (mag(v) > DATA_W'(thr)) && (v != '0);
    endfunction

    // full product to fixed point, floor rounding, saturated
    function automatic logic signed [DATA_W-1:0] mul_sat(logic signed [2*DATA_W-1:0] p);
        logic signed [2*DATA_W-1:0] q;
        q = p >>> FRAC_BITS;
        if (q > (2*DATA_W)'(SAT_MAX))
            return SAT_MAX;
        else if (q < (2*DATA_W)'(SAT_MIN))
            return SAT_MIN;
        else
            return DATA_W'(q);
    endfunction

    function automatic logic signed [DATA_W-1:0] sub_sat(logic signed [DATA_W-1:0] a,
                                                         logic signed [DATA_W-1:0] b);
        logic signed [DATA_W:0] d;
        d = (DATA_W+1)'(a) - (DATA_W+1)'(b);
        if (d > (DATA_W+1)'(SAT_MAX))
            return SAT_MAX;
        else if (d < (DATA_W+1)'(SAT_MIN))
            return SAT_MIN;
        else
            return DATA_W'(d);
    endfunction

endpackage

[hdl/gaussian_elimination_solver_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_elimination_solver_unit
// Fixed-point Gaussian elimination with pivot substitution and back
// substitution, matrix held in a two-read one-write RAM.
// ----------------------------------------------------------------------------
// Load the augmented matrix one word per element (column n is b). The word
// marked last_element starts the solve, during which no item is taken.
// Elimination updates each coefficient by RAM read, multiply, subtract and
// write, and divides once per eliminated row to get the row factor; back
// substitution reads, multiplies and subtracts per product and divides once
// per unknown. Results leave through a one-word output register; a
// no-solution run gives a single word with no_solution set.
module gaussian_elimination_solver_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_ready,
    input  gesu_pkg::item_t                      item,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output gesu_pkg::result_t                    result,
    input  logic                                 cfg_write,
    input  logic [gesu_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gesu_pkg::THR_W-1:0]           cfg_data
);

    localparam int DW = gesu_pkg::DATA_W;
    localparam int CW = gesu_pkg::CNT_W;
    localparam int AW = gesu_pkg::ADDR_W;

    gesu_pkg::state_t state_reg, state_next;

    logic [gesu_pkg::SIZE_W-1:0] size_reg;
    logic [gesu_pkg::THR_W-1:0]  thr_reg;
    logic [CW-1:0] n_reg, i_reg, j_reg, k_reg, s_reg, c_reg;
    logic signed [DW-1:0] piv_reg, f_reg, tmp_reg, x_reg;
    logic signed [2*DW-1:0] mulp_reg;
    logic                   res_valid_reg;
    gesu_pkg::result_t      res_reg;

    logic          item_acc, out_free, res_load;
    logic [CW-1:0] n_live;
    gesu_pkg::result_t res_next;

    // coefficient RAM ports
    logic          we;
    logic [AW-1:0] waddr, raddr_a, raddr_b;
    logic [DW-1:0] wdata, rdata_a_u, rdata_b_u;
    logic signed [DW-1:0] rd_a, rd_b;

    // solution store
    logic signed [DW-1:0] sol_mem [gesu_pkg::MAX_SIZE];
    logic signed [DW-1:0] sol_rd_reg;
    logic [gesu_pkg::IDX_W-1:0] sol_raddr;
    logic                 sol_we;

    gesu_pkg::div_req_t div_req;
    gesu_pkg::div_rsp_t div_rsp;

    assign n_live     = gesu_pkg::eff_size(size_reg);
    assign item_ready = (state_reg == gesu_pkg::ST_LOAD);
    assign item_acc   = item_valid && item_ready;
    assign out_free   = !res_valid_reg || result_ready;
    assign rd_a       = rdata_a_u;
    assign rd_b       = rdata_b_u;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    gesu_ram #(
        .WIDTH (DW),
        .DEPTH (gesu_pkg::DEPTH),
        .ADDR_W(AW)
    ) u_ram (
        .clk    (clk),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr_a(raddr_a),
        .raddr_b(raddr_b),
        .rdata_a(rdata_a_u),
        .rdata_b(rdata_b_u)
    );

    gesu_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .rsp  (div_rsp)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= gesu_pkg::SIZE_RESET;
            thr_reg  <= gesu_pkg::THR_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                gesu_pkg::CFG_MATRIX_SIZE:     size_reg <= cfg_data[gesu_pkg::SIZE_W-1:0];
                gesu_pkg::CFG_PIVOT_THRESHOLD: thr_reg  <= cfg_data;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gesu_pkg::ST_LOAD:
                if (item_acc && item.last_element)
                    state_next = (n_live == CW'(1)) ? gesu_pkg::ST_FIN_RD : gesu_pkg::ST_PIV_RD;
            gesu_pkg::ST_PIV_RD:   state_next = gesu_pkg::ST_PIV_CHK;
            gesu_pkg::ST_PIV_CHK:
                state_next = gesu_pkg::below(rd_a, thr_reg) ? gesu_pkg::ST_SRCH_RD
                                                           : gesu_pkg::ST_ROW_RD;
            gesu_pkg::ST_SRCH_RD:  state_next = gesu_pkg::ST_SRCH_CHK;
            gesu_pkg::ST_SRCH_CHK:
                if (gesu_pkg::usable(rd_a, thr_reg))
                    state_next = gesu_pkg::ST_SWP_RD;
                else if (s_reg + 1'b1 == n_reg)
                    state_next = gesu_pkg::ST_NOSOL;
                else
                    state_next = gesu_pkg::ST_SRCH_RD;
            gesu_pkg::ST_SWP_RD:   state_next = gesu_pkg::ST_SWP_CAP;
            gesu_pkg::ST_SWP_CAP:  state_next = gesu_pkg::ST_SWP_WR;
            gesu_pkg::ST_SWP_WR:
                state_next = (k_reg == n_reg) ? gesu_pkg::ST_ROW_RD : gesu_pkg::ST_SWP_RD;
            gesu_pkg::ST_ROW_RD:   state_next = gesu_pkg::ST_ROW_DIV;
            gesu_pkg::ST_ROW_DIV:  state_next = gesu_pkg::ST_ROW_WAIT;
            gesu_pkg::ST_ROW_WAIT:
                if (div_rsp.done)
                    state_next = gesu_pkg::ST_ELM_RD;
            gesu_pkg::ST_ELM_RD:   state_next = gesu_pkg::ST_ELM_MUL;
            gesu_pkg::ST_ELM_MUL:  state_next = gesu_pkg::ST_ELM_WR;
            gesu_pkg::ST_ELM_WR:
                if (k_reg != n_reg)
                    state_next = gesu_pkg::ST_ELM_RD;
                else if (j_reg + 1'b1 != n_reg)
                    state_next = gesu_pkg::ST_ROW_RD;
                else if (i_reg + 2'd2 == {1'b0, n_reg})
                    state_next = gesu_pkg::ST_FIN_RD;
                else
                    state_next = gesu_pkg::ST_PIV_RD;
            gesu_pkg::ST_FIN_RD:   state_next = gesu_pkg::ST_FIN_CHK;
            gesu_pkg::ST_FIN_CHK:
                state_next = gesu_pkg::below(rd_a, thr_reg) ? gesu_pkg::ST_NOSOL
                                                           : gesu_pkg::ST_BS_RD;
            gesu_pkg::ST_BS_RD:    state_next = gesu_pkg::ST_BS_X;
            gesu_pkg::ST_BS_X:
                state_next = (k_reg + 1'b1 == n_reg) ? gesu_pkg::ST_BS_DRD : gesu_pkg::ST_BS_TRD;
            gesu_pkg::ST_BS_TRD:   state_next = gesu_pkg::ST_BS_TMUL;
            gesu_pkg::ST_BS_TMUL:  state_next = gesu_pkg::ST_BS_TSUB;
            gesu_pkg::ST_BS_TSUB:
                state_next = (c_reg + 1'b1 == n_reg) ? gesu_pkg::ST_BS_DRD : gesu_pkg::ST_BS_TRD;
            gesu_pkg::ST_BS_DRD:   state_next = gesu_pkg::ST_BS_DIV;
            gesu_pkg::ST_BS_DIV:   state_next = gesu_pkg::ST_BS_WAIT;
            gesu_pkg::ST_BS_WAIT:
                if (div_rsp.done)
                    state_next = (k_reg == '0) ? gesu_pkg::ST_OUT_RD : gesu_pkg::ST_BS_RD;
            gesu_pkg::ST_OUT_RD:   state_next = gesu_pkg::ST_OUT_WR;
            gesu_pkg::ST_OUT_WR:
                if (out_free)
                    state_next = (k_reg + 1'b1 == n_reg) ? gesu_pkg::ST_LOAD : gesu_pkg::ST_OUT_RD;
            gesu_pkg::ST_NOSOL:
                if (out_free)
                    state_next = gesu_pkg::ST_LOAD;
            default:               state_next = gesu_pkg::ST_LOAD;
        endcase
    end

    // memory, divider and output controls
    always_comb
    begin
        we        = 1'b0;
        waddr     = gesu_pkg::cell_addr(j_reg, k_reg);
        wdata     = gesu_pkg::sub_sat(tmp_reg, gesu_pkg::mul_sat(mulp_reg));
        raddr_a   = gesu_pkg::cell_addr(i_reg, i_reg);
        raddr_b   = gesu_pkg::cell_addr(s_reg, k_reg);
        sol_raddr = c_reg[gesu_pkg::IDX_W-1:0];
        sol_we    = 1'b0;
        div_req   = '{start: 1'b0, num: rd_a, den: piv_reg};
        res_load  = 1'b0;
        res_next  = '{index: 4'(k_reg), solution: sol_rd_reg, no_solution: 1'b0,
                      last: (k_reg + 1'b1 == n_reg)};
        unique case (state_reg)
            gesu_pkg::ST_LOAD:
            begin
                we    = item_acc && (CW'(item.row) < n_live) && (item.col <= n_live);
                waddr = gesu_pkg::cell_addr(CW'(item.row), item.col);
                wdata = item.value;
            end
            gesu_pkg::ST_SRCH_RD:  raddr_a = gesu_pkg::cell_addr(s_reg, i_reg);
            gesu_pkg::ST_SWP_RD:   raddr_a = gesu_pkg::cell_addr(i_reg, k_reg);
            gesu_pkg::ST_SWP_CAP:
            begin
                we    = 1'b1;
                waddr = gesu_pkg::cell_addr(i_reg, k_reg);
                wdata = rd_b;
            end
            gesu_pkg::ST_SWP_WR:
            begin
                we    = 1'b1;
                waddr = gesu_pkg::cell_addr(s_reg, k_reg);
                wdata = tmp_reg;
            end
            gesu_pkg::ST_ROW_RD:   raddr_a = gesu_pkg::cell_addr(j_reg, i_reg);
            gesu_pkg::ST_ROW_DIV:  div_req.start = 1'b1;
            gesu_pkg::ST_ELM_RD:
            begin
                raddr_a = gesu_pkg::cell_addr(i_reg, k_reg);
                raddr_b = gesu_pkg::cell_addr(j_reg, k_reg);
            end
            gesu_pkg::ST_ELM_WR:   we = 1'b1;
            gesu_pkg::ST_FIN_RD:   raddr_a = gesu_pkg::cell_addr(n_reg - 1'b1, n_reg - 1'b1);
            gesu_pkg::ST_BS_RD:    raddr_a = gesu_pkg::cell_addr(k_reg, n_reg);
            gesu_pkg::ST_BS_TRD:   raddr_a = gesu_pkg::cell_addr(k_reg, c_reg);
            gesu_pkg::ST_BS_DRD:   raddr_a = gesu_pkg::cell_addr(k_reg, k_reg);
            gesu_pkg::ST_BS_DIV:   div_req = '{start: 1'b1, num: x_reg, den: rd_a};
            gesu_pkg::ST_BS_WAIT:  sol_we = div_rsp.done;
            gesu_pkg::ST_OUT_RD:   sol_raddr = k_reg[gesu_pkg::IDX_W-1:0];
            gesu_pkg::ST_OUT_WR:
            begin
                sol_raddr = k_reg[gesu_pkg::IDX_W-1:0];
                res_load  = out_free;
            end
            gesu_pkg::ST_NOSOL:
            begin
                res_load = out_free;
                res_next = '{index: 4'd0, solution: '0, no_solution: 1'b1, last: 1'b1};
            end
            default: ;
        endcase
    end

    // state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gesu_pkg::ST_LOAD;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_load)
                res_valid_reg <= 1'b1;
            else if (result_ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
            res_reg <= res_next;
    end

    // solution store
    always_ff @(posedge clk)
    begin
        if (sol_we)
            sol_mem[k_reg[gesu_pkg::IDX_W-1:0]] <= div_rsp.quot;
        sol_rd_reg <= sol_mem[sol_raddr];
    end

    // sequencer counters and working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg <= '0;
            i_reg <= '0;
            j_reg <= '0;
            k_reg <= '0;
            s_reg <= '0;
            c_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                gesu_pkg::ST_LOAD:
                    if (item_acc && item.last_element)
                    begin
                        n_reg <= n_live;
                        i_reg <= '0;
                    end
                gesu_pkg::ST_PIV_CHK:
                begin
                    s_reg <= i_reg + 1'b1;
                    j_reg <= i_reg + 1'b1;
                end
                gesu_pkg::ST_SRCH_CHK:
                    if (gesu_pkg::usable(rd_a, thr_reg))
                        k_reg <= i_reg;
                    else
                        s_reg <= s_reg + 1'b1;
                gesu_pkg::ST_SWP_RD:   k_reg <= k_reg;
                gesu_pkg::ST_SWP_WR:   k_reg <= k_reg + 1'b1;
                gesu_pkg::ST_ROW_WAIT:
                    if (div_rsp.done)
                        k_reg <= i_reg;
                gesu_pkg::ST_ELM_WR:
                    if (k_reg != n_reg)
                        k_reg <= k_reg + 1'b1;
                    else if (j_reg + 1'b1 != n_reg)
                        j_reg <= j_reg + 1'b1;
                    else
                        i_reg <= i_reg + 1'b1;
                gesu_pkg::ST_FIN_CHK:  k_reg <= n_reg - 1'b1;
                gesu_pkg::ST_BS_X:     c_reg <= k_reg + 1'b1;
                gesu_pkg::ST_BS_TSUB:  c_reg <= c_reg + 1'b1;
                gesu_pkg::ST_BS_WAIT:
                    if (div_rsp.done && k_reg != '0)
                        k_reg <= k_reg - 1'b1;
                gesu_pkg::ST_OUT_WR:
                    if (out_free)
                        k_reg <= k_reg + 1'b1;
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            gesu_pkg::ST_PIV_CHK:  piv_reg <= rd_a;
            gesu_pkg::ST_SWP_CAP:
            begin
                tmp_reg <= rd_a;
                if (k_reg == i_reg)
                    piv_reg <= rd_b;
            end
            gesu_pkg::ST_ROW_WAIT:
                if (div_rsp.done)
                    f_reg <= div_rsp.quot;
            gesu_pkg::ST_ELM_MUL:
            begin
                mulp_reg <= f_reg * rd_a;
                tmp_reg  <= rd_b;
            end
            gesu_pkg::ST_BS_X:     x_reg <= rd_a;
            gesu_pkg::ST_BS_TMUL:  mulp_reg <= rd_a * sol_rd_reg;
            gesu_pkg::ST_BS_TSUB:  x_reg <= gesu_pkg::sub_sat(x_reg, gesu_pkg::mul_sat(mulp_reg));
            default: ;
        endcase
    end

endmodule

[hdl/gesu_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gesu_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module gesu_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 272,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [WIDTH-1:0]  rdata_a,
    output logic [WIDTH-1:0]  rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

[hdl/gesu_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gesu_div
// Fixed-point divider, (num << FRAC_BITS) / den, one quotient bit a cycle,
// truncated toward zero and saturated.
// ----------------------------------------------------------------------------
module gesu_div (
    input  logic               clk,
    input  logic               rst_n,
    input  gesu_pkg::div_req_t req,
    output gesu_pkg::div_rsp_t rsp
);

    localparam int DW = gesu_pkg::DATA_W;
    localparam int NW = gesu_pkg::NUM_W;

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [gesu_pkg::DCNT_W-1:0] cnt_reg, cnt_next;
    logic [DW:0]                 rem_reg, rem_next;
    logic [NW-1:0]               quo_reg, quo_next;
    logic [DW-1:0]               den_reg, den_next;
    logic                        neg_reg, neg_next;
    logic [DW:0]                 rem_sh;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    // one restoring step per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        rem_sh    = {rem_reg[DW-1:0], quo_reg[NW-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = gesu_pkg::DCNT_W'(NW);
            rem_next  = '0;
            quo_next  = {gesu_pkg::mag(req.num), {gesu_pkg::FRAC_BITS{1'b0}}};
            den_next  = gesu_pkg::mag(req.den);
            neg_next  = req.num[DW-1] ^ req.den[DW-1];
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = rem_sh - {1'b0, den_reg};
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == gesu_pkg::DCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // sign and saturate
    always_comb
    begin
        rsp.done = done_reg;
        if (!neg_reg)
            rsp.quot = (quo_reg > NW'(gesu_pkg::SAT_MAX)) ? gesu_pkg::SAT_MAX
                                                         : DW'(quo_reg[DW-1:0]);
        else
            rsp.quot = (quo_reg > NW'({1'b1, {(DW-1){1'b0}}})) ? gesu_pkg::SAT_MIN
                                                               : DW'(-quo_reg[DW-1:0]);
    end

endmodule

[hdl/gesu_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gesu_chk
// Port-level checks of the solver, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gesu_chk (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           item_valid,
    input logic                           item_ready,
    input gesu_pkg::item_t                item,
    input logic                           result_valid,
    input logic                           result_ready,
    input gesu_pkg::result_t              result,
    input logic                           cfg_write,
    input logic [gesu_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [gesu_pkg::THR_W-1:0]     cfg_data
);

    logic cfg_seen;
    assign cfg_seen = cfg_write && (cfg_index == gesu_pkg::CFG_MATRIX_SIZE) && (cfg_data != '0);

    // stalled result word holds
    `ASSERT_STD(a_res_hold, result_valid && !result_ready |=> result_valid && $stable(result), "result word changed while stalled")

    // no-solution word is the whole run
    `ASSERT_STD(a_nosol_form, result_valid && result.no_solution |-> result.last && result.solution == '0 && result.index == '0, "malformed no-solution word")

    // solve starts right after the final element
    `ASSERT_STD(a_solve_busy, item_valid && item_ready && item.last_element |=> !item_ready, "input taken during solve")

    // a nonzero size write outside loading sees no input handshake
    `ASSERT_STD(a_cfg_idle, cfg_seen && !item_ready |-> !(item_valid && item_ready), "config write seen during solve handshake")

endmodule

bind gaussian_elimination_solver_unit gesu_chk u_gesu_chk (.*);
